// File: rtl/swaf_pkg.sv
// Shared types and constants for the sliding window anagram finder.
`default_nettype none

package swaf_pkg;

  localparam int ALPHABET          = 26;
  localparam int LETTER_W          = 5;
  localparam int DEF_MAX_PATTERN   = 256;
  localparam int DEF_INDEX_BITS    = 16;
  localparam int START_W           = 16;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Histogram update for one processed word.
  typedef struct packed {
    logic    clear_all;
    logic    clear_window;
    logic    pat_inc;
    letter_t pat_letter;
    logic    txt_step;
    letter_t txt_letter;
    logic    drop_old;
    letter_t old_letter;
  } hist_ctl_t;

endpackage

`default_nettype wire

// File: rtl/swaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swaf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/swaf_hist.sv
// Pattern and window letter histograms with the 26-way equality compare.
`default_nettype none

module swaf_hist import swaf_pkg::*; #(
  parameter int CNT_W = 9
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hist_ctl_t ctl,
  output logic           eq_nxt
);

  logic [CNT_W-1:0] pat_r   [ALPHABET];
  logic [CNT_W-1:0] pat_nxt [ALPHABET];
  logic [CNT_W-1:0] win_r   [ALPHABET];
  logic [CNT_W-1:0] win_nxt [ALPHABET];

  // Each bin updates itself; no indexed reads of the histograms.
  always_comb begin
    logic inc;
    logic dec;
    logic pinc;
    eq_nxt = 1'b1;
    for (int i = 0; i < ALPHABET; i++) begin
      pinc = ctl.pat_inc && (ctl.pat_letter == LETTER_W'(i));
      inc  = ctl.txt_step && (ctl.txt_letter == LETTER_W'(i));
      dec  = ctl.drop_old && (ctl.old_letter == LETTER_W'(i)) && (win_r[i] != '0);
      if (ctl.clear_all) begin
        pat_nxt[i] = '0;
      end else begin
        pat_nxt[i] = pat_r[i] + CNT_W'(pinc);
      end
      if (ctl.clear_all || ctl.clear_window) begin
        win_nxt[i] = '0;
      end else begin
        win_nxt[i] = win_r[i] + CNT_W'(inc) - CNT_W'(dec);
      end
      eq_nxt = eq_nxt && (pat_r[i] == win_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ALPHABET; i++) begin
      if (!rst_n) begin
        pat_r[i] <= '0;
        win_r[i] <= '0;
      end else begin
        pat_r[i] <= pat_nxt[i];
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sliding_window_anagram_finder_unit.sv
// Text words pass the input register, then their results the result register.
// One word per cycle unless a held result stalls; clear and pattern words give
// no result. The ring of recent letters is a RAM read ahead at the next pointer.
// Reset (rst_n low, synchronous) empties both stages and zeroes the histograms,
// lengths, position and ring pointer; ring contents stay undefined until written.
`default_nettype none

module sliding_window_anagram_finder_unit import swaf_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] start_index
  output logic [0:0]       out_tuser   // [0] match
);

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int PTR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SUM_W  = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
  localparam int EXT_W  = (INDEX_BITS > START_W) ? INDEX_BITS : START_W;

  // Input register
  logic      in_v_r,   in_v_nxt;
  cmd_t      cmd_r,    cmd_nxt;
  letter_t   letter_r, letter_nxt;

  // Block state
  logic [LEN_W-1:0]      len_r,  len_nxt;
  logic [LEN_W-1:0]      fill_r, fill_nxt;
  logic [INDEX_BITS-1:0] pos_r,  pos_nxt;
  logic [PTR_W-1:0]      ptr_r,  ptr_nxt;

  // Ring read bypass
  logic    byp_v_r, byp_v_nxt;
  letter_t byp_d_r;

  // Result register
  logic               out_v_r, out_v_nxt;
  logic               match_r, match_nxt;
  logic [START_W-1:0] start_r, start_nxt;

  logic        advance;
  logic        out_free;
  logic        txt_step;
  logic        full;
  logic        eq_nxt;
  logic        ring_we;
  letter_t     ring_rdata;
  letter_t     old_letter;
  hist_ctl_t   hctl;
  logic [LEN_W:0]        ptr_inc;
  logic [SUM_W-1:0]      sum;
  logic [EXT_W-1:0]      start_ext;

  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && ((cmd_r != CMD_TEXT) || out_free);
  assign in_tready = !in_v_r || advance;

  assign txt_step   = advance && (cmd_r == CMD_TEXT) && (len_r != '0);
  assign full       = fill_r >= len_r;
  assign old_letter = byp_v_r ? byp_d_r : ring_rdata;
  assign ring_we    = txt_step;
  assign ptr_inc    = (LEN_W + 1)'(ptr_r) + 1'b1;

  assign sum       = SUM_W'(pos_r) - SUM_W'(len_r) + 1'b1;
  assign start_ext = EXT_W'(sum[INDEX_BITS-1:0]);

  always_comb begin
    in_v_nxt   = in_v_r;
    cmd_nxt    = cmd_r;
    letter_nxt = letter_r;
    if (in_tready) begin
      in_v_nxt   = in_tvalid;
      cmd_nxt    = cmd_t'(in_tuser);
      letter_nxt = in_tdata[LETTER_W-1:0];
    end

    len_nxt  = len_r;
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    ptr_nxt  = ptr_r;

    hctl              = '0;
    hctl.pat_letter   = letter_r;
    hctl.txt_letter   = letter_r;
    hctl.old_letter   = old_letter;

    out_v_nxt = out_v_r && !out_tready;
    match_nxt = match_r;
    start_nxt = start_r;

    if (advance) begin
      case (cmd_r)
        CMD_CLEAR: begin
          hctl.clear_all = 1'b1;
          len_nxt  = '0;
          fill_nxt = '0;
          pos_nxt  = '0;
          ptr_nxt  = '0;
        end
        CMD_PATTERN: begin
          hctl.clear_window = 1'b1;
          fill_nxt = '0;
          pos_nxt  = '0;
          ptr_nxt  = '0;
          // drop letters outside the alphabet and beyond the maximum length
          if ((letter_r < LETTER_W'(ALPHABET)) && (len_r != LEN_W'(MAX_PATTERN))) begin
            hctl.pat_inc = 1'b1;
            len_nxt      = len_r + 1'b1;
          end
        end
        CMD_TEXT: begin
          pos_nxt   = pos_r + 1'b1;
          out_v_nxt = 1'b1;
          match_nxt = 1'b0;
          start_nxt = '0;
          if (txt_step) begin
            hctl.txt_step = 1'b1;
            hctl.drop_old = full;
            fill_nxt = full ? fill_r : fill_r + 1'b1;
            ptr_nxt  = (ptr_inc >= (LEN_W + 1)'(len_r)) ? '0 : ptr_inc[PTR_W-1:0];
            if ((fill_nxt == len_r) && eq_nxt) begin
              match_nxt = 1'b1;
              start_nxt = start_ext[START_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end

    // The registered read misses a write to the slot being fetched; forward it.
    byp_v_nxt = ring_we && (ptr_r == ptr_nxt);
  end

  swaf_hist #(
    .CNT_W (LEN_W)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hctl),
    .eq_nxt (eq_nxt)
  );

  swaf_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (letter_r),
    .raddr (ptr_nxt),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      byp_v_r <= 1'b0;
      len_r   <= '0;
      fill_r  <= '0;
      pos_r   <= '0;
      ptr_r   <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      byp_v_r <= byp_v_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      ptr_r   <= ptr_nxt;
    end
    cmd_r    <= cmd_nxt;
    letter_r <= letter_nxt;
    byp_d_r  <= letter_r;
    match_r  <= match_nxt;
    start_r  <= start_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = start_r;
  assign out_tuser  = match_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_r)
    else $error("window fill exceeds pattern length");

  a_ptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> ((LEN_W + 1)'(ptr_r) < (LEN_W + 1)'(len_r)))
    else $error("ring pointer outside the window");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (cmd_r == CMD_TEXT)) |=> (pos_r == $past(pos_r) + 1'b1))
    else $error("text position did not advance on a text word");

  a_no_stall_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !(advance && (cmd_r == CMD_TEXT)))
    else $error("text word processed while result register is held");

endmodule

`default_nettype wire

// File: dv/sliding_window_anagram_finder_unit_tb.sv
// Self-checking testbench for the sliding window anagram finder unit.
`timescale 1ns / 100ps

import swaf_pkg::*;

typedef struct {
  logic        hit;
  logic [15:0] start;
} window_result_t;

typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

class window_scoreboard;
  localparam int MAX_K = DEF_MAX_PATTERN;
  localparam int SHOW_LIMIT = 30;

  bit [8:0]       pat_count[ALPHABET];
  bit [8:0]       win_count[ALPHABET];
  int unsigned    pat_len;
  int unsigned    win_fill;
  int unsigned    ring_ptr;
  bit [15:0]      text_pos;
  letter_t        recent[MAX_K];
  window_result_t pending_windows[$];
  int             errors;

  function new();
    clear_all();
    errors = 0;
  endfunction

  function void clear_text();
    foreach (win_count[i]) win_count[i] = '0;
    win_fill = 0;
    text_pos = '0;
    ring_ptr = 0;
  endfunction

  function void clear_all();
    foreach (pat_count[i]) pat_count[i] = '0;
    pat_len = 0;
    clear_text();
  endfunction

  function bit counts_agree();
    foreach (pat_count[i]) begin
      if (pat_count[i] != win_count[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Slide the window by one text letter and queue the result for the new window.
  function void slide_window(letter_t l);
    window_result_t r;
    letter_t        old;
    bit [15:0]      pos;
    bit             hit;
    pos = text_pos;
    hit = 1'b0;
    if (pat_len > 0) begin
      if (win_fill >= pat_len) begin
        old = recent[ring_ptr];
        if (old < ALPHABET && win_count[old] > 0) win_count[old]--;
      end else begin
        win_fill++;
      end
      recent[ring_ptr] = l;
      if (l < ALPHABET) win_count[l]++;
      ring_ptr = (ring_ptr + 1 >= pat_len) ? 0 : ring_ptr + 1;
      hit = (win_fill == pat_len) && counts_agree();
    end
    r.hit = hit;
    r.start = hit ? (pos - 16'(pat_len) + 16'd1) : 16'd0;
    pending_windows = {pending_windows, r};
    text_pos = text_pos + 16'd1;
  endfunction

  function void note_word(cmd_t c, letter_t l);
    case (c)
      CMD_CLEAR: clear_all();
      CMD_PATTERN: begin
        clear_text();
        if (l < ALPHABET && pat_len < MAX_K) begin
          pat_count[l]++;
          pat_len++;
        end
      end
      CMD_TEXT: slide_window(l);
      default: ;
    endcase
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= SHOW_LIMIT) $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  task check_result(logic match, logic [15:0] start);
    window_result_t w;
    if (pending_windows.size() == 0) begin
      report_mismatch($sformatf("unexpected word match=%0b start=%0d", match, start));
      return;
    end
    w = pending_windows.pop_front();
    if (match !== w.hit)
      report_mismatch($sformatf("match %0b, expected %0b", match, w.hit));
    if (start !== w.start)
      report_mismatch($sformatf("start_index %0d, expected %0d", start, w.start));
  endtask
endclass

module sliding_window_anagram_finder_unit_tb;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [4:0] letter, [7:5] zero
  logic [1:0]  in_tuser = '0;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] start_index
  logic [0:0]  out_tuser;       // [0] match

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;

  window_scoreboard sb = new();

  sliding_window_anagram_finder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: hold off while a long stall is pending, else stall at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser[0], out_tdata);
  end

  task automatic set_idle_mode(idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default:   begin send_idle_pct = 6;  recv_stall_pct = 6;  end
    endcase
  endtask

  // Call at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(cmd_t c, letter_t l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {3'b000, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(c, l);
    if (c != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_windows.size() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    send_word(CMD_TEXT, 5'd0);      // empty pattern never hits
    send_word(CMD_NONE, 5'd31);     // ignored
    send_word(CMD_PATTERN, 5'd0);
    send_word(CMD_PATTERN, 5'd25);
    send_word(CMD_PATTERN, 5'd31);  // out of range: dropped
    send_word(CMD_TEXT, 5'd25);     // window still filling
    send_word(CMD_TEXT, 5'd0);
    send_word(CMD_TEXT, 5'd31);     // out-of-range text letter spoils the window
    send_word(CMD_TEXT, 5'd0);
    send_word(CMD_TEXT, 5'd25);
    send_word(CMD_PATTERN, 5'd1);   // grow pattern, restart text side
    send_word(CMD_TEXT, 5'd1);
    send_word(CMD_TEXT, 5'd25);
    send_word(CMD_TEXT, 5'd0);
    send_word(CMD_TEXT, 5'd0);
    send_word(CMD_CLEAR, 5'd31);
    send_word(CMD_TEXT, 5'd16);
    send_word(CMD_NONE, 5'd0);
  endtask

  // Fill the pattern to its limit with one letter, then overflow it.
  task automatic run_long_pattern();
    letter_t fill;
    fill = letter_t'($urandom_range(0, ALPHABET - 1));
    send_word(CMD_CLEAR, 5'd0);
    repeat (DEF_MAX_PATTERN + 3) send_word(CMD_PATTERN, fill);
    repeat (DEF_MAX_PATTERN + 2) send_word(CMD_TEXT, fill);
    send_word(CMD_TEXT, fill ^ 5'd1);
    repeat (4) send_word(CMD_TEXT, fill);
  endtask

  task automatic run_backpressure();
    set_idle_mode(IDLE_NONE);
    send_word(CMD_CLEAR, 5'd0);
    send_word(CMD_PATTERN, 5'd2);
    send_word(CMD_PATTERN, 5'd3);
    hold_left = 300;
    repeat (48) send_word(CMD_TEXT, letter_t'($urandom_range(2, 4)));
    wait_drained();
  endtask

  // Usually clear, build a pattern from a narrow alphabet, then stream mostly
  // shuffled copies of it with some stray letters and commands mixed in.
  task automatic run_episode();
    letter_t pat[$];
    letter_t copy[$];
    letter_t tmp;
    letter_t l;
    int      k, span, base, n_text, sent, pick, sw, j;
    if ($urandom_range(0, 99) < 75) send_word(CMD_CLEAR, letter_t'($urandom_range(0, 31)));
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    span = $urandom_range(1, 4);
    base = $urandom_range(0, ALPHABET - span);
    for (j = 0; j < k; j++) begin
      pat = {pat, letter_t'(base + $urandom_range(0, span - 1))};
      send_word(CMD_PATTERN, pat[j]);
    end
    if ($urandom_range(0, 9) == 0) send_word(CMD_PATTERN, letter_t'($urandom_range(26, 31)));
    n_text = $urandom_range(k, 4 * k + 8);
    sent = 0;
    while (sent < n_text) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        copy = pat;
        for (j = copy.size() - 1; j > 0; j--) begin
          sw = $urandom_range(0, j);
          tmp = copy[j];
          copy[j] = copy[sw];
          copy[sw] = tmp;
        end
        foreach (copy[i]) send_word(CMD_TEXT, copy[i]);
        sent += copy.size();
      end else if (pick < 90) begin
        send_word(CMD_TEXT, letter_t'(base + $urandom_range(0, span - 1)));
        sent++;
      end else if (pick < 96) begin
        send_word(CMD_TEXT, letter_t'($urandom_range(0, 31)));
        sent++;
      end else if (pick < 98) begin
        send_word(CMD_NONE, letter_t'($urandom_range(0, 31)));
      end else begin
        l = letter_t'($urandom_range(0, 31));
        if (l < ALPHABET) pat = {pat, l};
        send_word(CMD_PATTERN, l);
      end
    end
  endtask

  initial begin
    int base_items;
    int episode;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    set_idle_mode(IDLE_NONE);
    run_directed();
    wait_drained();
    set_idle_mode(IDLE_BOTH);
    run_long_pattern();
    wait_drained();
    run_backpressure();
    base_items = items_sent;
    episode = 0;
    while (items_sent - base_items < RANDOM_ITEMS) begin
      if (episode % 6 == 0) begin
        wait_drained();
        set_idle_mode(idle_mode_t'((episode / 6) % 4));
      end
      run_episode();
      episode++;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending_windows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
